@@ hdl/bhq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types and constants of the 3x3 box heightmap quantizer.
// ----------------------------------------------------------------------------
package bhq_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_idx_e;

  localparam int CFG_DATA_W = 11;
  localparam logic [10:0] WIDTH_RST    = 11'd1024;
  localparam logic [10:0] HEIGHT_RST   = 11'd1024;
  localparam logic [2:0]  CHANNELS_RST = 3'd1;
  localparam logic [2:0]  CHANNELS_MAX = 3'd4;

  localparam int PIX_W = 8;
  localparam int VSUM_W = 10;   // three bytes
  localparam int SUM_W = 12;    // nine bytes
  localparam int POS_W = 12;    // row or column up to 4095
  localparam int NRES = 4;      // results per word at most

  // height = trunc(32767 * (S - 90) / 2295)
  localparam logic [SUM_W-1:0] SUM_BIAS = 12'd90;
  localparam int MAG_W = 27;
  localparam int QUANT_SHIFT = 39;
  localparam int QUANT_MUL_W = 28;
  localparam logic [63:0] QUANT_MUL_L = ((64'd1 << 39) + 64'd2294) / 64'd2295;
  localparam logic [QUANT_MUL_W-1:0] QUANT_MUL = QUANT_MUL_L[QUANT_MUL_W-1:0];
  localparam int PROD_W = MAG_W + QUANT_MUL_W;

  // result slots: 0 upper row left, 1 upper row right edge,
  // 2 last row left, 3 last row right edge (frame end)
  typedef struct packed {
    logic [NRES-1:0]             mask;
    logic [NRES-1:0][SUM_W-1:0]  sums;
    logic [POS_W-1:0]            row;
    logic [POS_W-1:0]            col;
  } job_t;

endpackage
`default_nettype wire

@@ hdl/bhq_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_front
// Byte intake, channel select, line buffers and column window; emits jobs.
// ----------------------------------------------------------------------------
module bhq_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WW = 11,
  parameter int HW = 11
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  restart_i,
  input  wire logic [WW-1:0]         width_i,
  input  wire logic [HW-1:0]         height_i,
  input  wire logic [2:0]            chans_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            pixel_byte_i,
  output bhq_pkg::job_t              job_o,
  output logic                       job_push_o,
  input  wire logic                  q_full_i
);
  import bhq_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [1:0]    ch_q, ch_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [2*SUM_W-1:0] win0_q, win1_q;

  logic s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_d_q;
  logic [RW-1:0] s1_r_q;
  logic [CW-1:0] s1_c_q;
  logic s1_rg1_q, s1_rg2_q, s1_cg1_q, s1_cg2_q, s1_clast_q, s1_rlast_q;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q, fwd_up_q, fwd_mid_q;
  logic fwd_q;

  logic accept, take, fire, col_last, row_last;
  logic [PIX_W-1:0] up_eff, mid_eff;
  logic [VSUM_W-1:0] va, vb;
  logic [SUM_W-1:0] va_x, vb_x, p1a, p2a, p1b, p2b;

  assign fire       = s1_valid_q && !q_full_i;
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = accept && (ch_q == 2'd0);
  assign col_last   = (WW'(col_q) == WW'(width_i - 1'b1));
  assign row_last   = (HW'(row_q) == height_i - 1'b1);

  always_comb begin
    ch_d = ch_q;
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      ch_d = (({1'b0, ch_q} + 3'd1) >= chans_i) ? 2'd0 : ch_q + 2'd1;
    end
    if (take) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    s1_valid_d = take ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
      col_q <= '0;
      row_q <= '0;
      s1_valid_q <= 1'b0;
      win0_q <= '0;
      win1_q <= '0;
      fwd_q <= 1'b0;
    end else if (restart_i) begin
      ch_q <= '0;
      col_q <= '0;
      row_q <= '0;
      s1_valid_q <= 1'b0;
      win0_q <= '0;
      win1_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      ch_q <= ch_d;
      col_q <= col_d;
      row_q <= row_d;
      s1_valid_q <= s1_valid_d;
      if (fire) begin
        win1_q <= win0_q;
        win0_q <= {vb_x, va_x};
      end
      if (take) begin
        fwd_q <= fire && (s1_c_q == col_q);
      end
    end
  end

  // sample stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_d_q <= pixel_byte_i;
      s1_r_q <= row_q;
      s1_c_q <= col_q;
      s1_rg1_q <= (row_q != '0);
      s1_rg2_q <= (RW'(row_q) >= RW'(2)) && (MAX_HEIGHT > 2);
      s1_cg1_q <= (col_q != '0);
      s1_cg2_q <= (CW'(col_q) >= CW'(2)) && (MAX_WIDTH > 2);
      s1_clast_q <= col_last;
      s1_rlast_q <= row_last;
      fwd_up_q <= mid_eff;
      fwd_mid_q <= s1_d_q;
    end
  end

  // line buffers: write behind, read ahead
  always_ff @(posedge clk_i) begin
    if (fire) begin
      upper_mem[s1_c_q] <= mid_eff;
      middle_mem[s1_c_q] <= s1_d_q;
    end
    if (take) begin
      up_rd_q <= upper_mem[col_q];
      mid_rd_q <= middle_mem[col_q];
    end
  end

  // same column written in the cycle it was read: take the fresh word
  assign up_eff  = fwd_q ? fwd_up_q : up_rd_q;
  assign mid_eff = fwd_q ? fwd_mid_q : mid_rd_q;

  always_comb begin
    va = VSUM_W'(s1_rg2_q ? up_eff : mid_eff) + VSUM_W'(mid_eff) + VSUM_W'(s1_d_q);
    vb = VSUM_W'(s1_rg1_q ? mid_eff : s1_d_q) + VSUM_W'(s1_d_q) + VSUM_W'(s1_d_q);
    va_x = SUM_W'(va);
    vb_x = SUM_W'(vb);
    p1a = win0_q[SUM_W-1:0];
    p2a = win1_q[SUM_W-1:0];
    p1b = win0_q[2*SUM_W-1:SUM_W];
    p2b = win1_q[2*SUM_W-1:SUM_W];
    job_o.sums[0] = (s1_cg2_q ? p2a : p1a) + p1a + va_x;
    job_o.sums[1] = (s1_cg1_q ? p1a : va_x) + va_x + va_x;
    job_o.sums[2] = (s1_cg2_q ? p2b : p1b) + p1b + vb_x;
    job_o.sums[3] = (s1_cg1_q ? p1b : vb_x) + vb_x + vb_x;
    job_o.mask = {s1_rlast_q && s1_clast_q, s1_rlast_q && s1_cg1_q,
                  s1_rg1_q && s1_clast_q, s1_rg1_q && s1_cg1_q};
    job_o.row = POS_W'(s1_r_q);
    job_o.col = POS_W'(s1_c_q);
  end

  assign job_push_o = fire && (job_o.mask != '0);

endmodule
`default_nettype wire

@@ hdl/bhq_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module bhq_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          flush_i,
  input  wire logic          push_i,
  input  bhq_pkg::job_t      push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output bhq_pkg::job_t      pop_job_o,
  output logic               empty_o
);
  import bhq_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign pop_job_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else if (flush_i) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_job_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("job queue count out of range");

endmodule
`default_nettype wire

@@ hdl/bhq_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_back
// Splits jobs into results and quantizes each box sum to a signed height.
// ----------------------------------------------------------------------------
module bhq_back #(
  parameter int HW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          flush_i,
  input  wire logic [HW-1:0] height_i,
  input  bhq_pkg::job_t      job_i,
  input  wire logic          job_empty_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [15:0]        height_value_o,
  output logic [9:0]         out_row_o,
  output logic [9:0]         out_col_o,
  output logic [19:0]        store_index_o,
  output logic               frame_last_o
);
  import bhq_pkg::*;

  job_t            job_q;
  logic [NRES-1:0] rem_q, rem_d, sel;
  logic            en, pick;

  logic p1_v_q, p2_v_q, p3_v_q, o_v_q;
  logic [SUM_W-1:0] p1_mag_q;
  logic p1_neg_q, p2_neg_q, p3_neg_q;
  logic p1_last_q, p2_last_q, p3_last_q;
  logic [POS_W-1:0] p1_row_q, p2_row_q, p3_row_q, p1_col_q, p2_col_q, p3_col_q;
  logic [MAG_W-1:0] p2_x_q;
  logic [19:0] p2_sidx_q, p3_sidx_q;
  logic [PROD_W-1:0] p3_prod_q;

  logic [SUM_W-1:0] s_sum;
  logic [15:0] q_abs;

  assign en   = !o_v_q || !out_stall_i;
  assign pick = en && (rem_q != '0);
  assign sel  = rem_q & (~rem_q + 1'b1);

  always_comb begin
    rem_d = pick ? (rem_q & ~sel) : rem_q;
    job_pop_o = !job_empty_i && (rem_d == '0);
    if (job_pop_o) rem_d = job_i.mask;
  end

  always_comb begin
    s_sum = job_q.sums[0];
    for (int i = 0; i < NRES; i++) begin
      if (sel[i]) s_sum = job_q.sums[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (flush_i) begin
      rem_q <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      if (en) begin
        p1_v_q <= pick;
        p2_v_q <= p1_v_q;
        p3_v_q <= p2_v_q;
        o_v_q <= p3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    if (en) begin
      // select a slot, split sign and magnitude of the sum minus the bias
      p1_neg_q <= (s_sum < SUM_BIAS);
      p1_mag_q <= (s_sum < SUM_BIAS) ? SUM_BIAS - s_sum : s_sum - SUM_BIAS;
      p1_row_q <= (sel[2] || sel[3]) ? job_q.row : job_q.row - 1'b1;
      p1_col_q <= (sel[1] || sel[3]) ? job_q.col : job_q.col - 1'b1;
      p1_last_q <= sel[3];
      // scale by 32767 and form the store index
      p2_x_q <= (MAG_W'(p1_mag_q) << 15) - MAG_W'(p1_mag_q);
      p2_sidx_q <= 20'(p1_col_q * height_i + (POS_W + HW)'(p1_row_q));
      p2_neg_q <= p1_neg_q;
      p2_row_q <= p1_row_q;
      p2_col_q <= p1_col_q;
      p2_last_q <= p1_last_q;
      // divide by 2295 through its reciprocal
      p3_prod_q <= PROD_W'(p2_x_q) * PROD_W'(QUANT_MUL);
      p3_sidx_q <= p2_sidx_q;
      p3_neg_q <= p2_neg_q;
      p3_row_q <= p2_row_q;
      p3_col_q <= p2_col_q;
      p3_last_q <= p2_last_q;
      height_value_o <= p3_neg_q ? 16'(-q_abs) : q_abs;
      out_row_o <= p3_row_q[9:0];
      out_col_o <= p3_col_q[9:0];
      store_index_o <= p3_sidx_q;
      frame_last_o <= p3_last_q;
    end
  end

  assign q_abs = p3_prod_q[QUANT_SHIFT +: 16];
  assign out_valid_o = o_v_q;

endmodule
`default_nettype wire

@@ hdl/box3x3_heightmap_quantizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// box3x3_heightmap_quantizer
// 3x3 replicated-border box smoothing of channel 0, quantized to 16-bit heights.
// ----------------------------------------------------------------------------
// Input channel: one image byte per word (in_valid_i / in_stall_o), row-major,
// channel_count bytes per pixel; bytes other than channel 0 only advance the
// channel count. The block takes one byte per cycle while its job queue has
// room; each channel-0 byte gives zero to four results, and the back end
// delivers one result per cycle while its output is not stalled, so the input
// stalls where a byte yields more than one result (right edges, last row).
// Output channel (out_valid_o / out_stall_i): results in order; a result of
// row r appears once the same column of row r+1 (and its right neighbour)
// has come in. The first result of a releasing byte passes through one front
// stage, the queue, the job register, three arithmetic stages and the output
// register.
// A stall on the output freezes the back pipeline; the queue then fills and
// the input stalls in turn. Nothing is dropped.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// always ready. A write to a register restarts the frame at row 0. Write only
// while idle. Reset loads 1024 x 1024, one byte per pixel; line buffers hold
// no reset value, and words not yet written in a frame never reach a result.
// ----------------------------------------------------------------------------
module box3x3_heightmap_quantizer #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  pixel_byte_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      height_value_o,
  output logic [9:0]       out_row_o,
  output logic [9:0]       out_col_o,
  output logic [19:0]      store_index_o,
  output logic             frame_last_o
);
  import bhq_pkg::*;

  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                      $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
  localparam int HW = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                      $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;

  logic [10:0] width_q, height_q;
  logic [2:0]  chans_q;
  logic        cfg_wr, restart;
  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [2:0]    chans_eff;

  job_t push_job, pop_job;
  logic push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;

  always_comb begin
    restart = 1'b0;
    unique case (cfg_index_i)
      CFG_WIDTH, CFG_HEIGHT, CFG_CHANNELS: restart = cfg_wr;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      chans_q <= CHANNELS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_WIDTH:    width_q <= cfg_data_i;
        CFG_HEIGHT:   height_q <= cfg_data_i;
        CFG_CHANNELS: chans_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // saturate registers into their legal range
  always_comb begin
    width_eff = (width_q == '0) ? WW'(1) :
                ((WW'(width_q) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_q));
    height_eff = (height_q == '0) ? HW'(1) :
                 ((HW'(height_q) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_q));
    chans_eff = (chans_q == '0) ? 3'd1 :
                ((chans_q > CHANNELS_MAX) ? CHANNELS_MAX : chans_q);
  end

  bhq_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WW        (WW),
    .HW        (HW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .chans_i     (chans_eff),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_byte_i(pixel_byte_i),
    .job_o       (push_job),
    .job_push_o  (push),
    .q_full_i    (q_full)
  );

  bhq_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flush_i   (restart),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (q_full),
    .pop_i     (pop),
    .pop_job_o (pop_job),
    .empty_o   (q_empty)
  );

  bhq_back #(
    .HW(HW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .flush_i       (restart),
    .height_i      (height_eff),
    .job_i         (pop_job),
    .job_empty_i   (q_empty),
    .job_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .height_value_o(height_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .store_index_o (store_index_o),
    .frame_last_o  (frame_last_o)
  );

endmodule
`default_nettype wire
